// File: hw/rtl/ttl_pkg.sv
// ttl_pkg: shared types, constants and lookup tables for the thermistor linearizer
// no dependencies; imported by ttl_ctrl, ttl_dp and thermistor_table_linearizer
`timescale 1ns / 1ps
package ttl_pkg;

  localparam int ROM_POINTS         = 150;
  localparam int TABLE_POINTS_DEF   = 150;
  localparam int ADC_FULL_SCALE_DEF = 1024;
  localparam int IDX_W              = $clog2(ROM_POINTS);
  localparam int CODE_W             = 10;
  localparam int V_W                = 21;
  localparam int VOL_W              = 19;
  localparam int SLOPE_W            = 18;
  localparam int TEMP_W             = 16;
  localparam int STATUS_W           = 2;
  localparam int TEMP_OFFSET        = 39;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 2'd0,
    ST_TOO_COLD = 2'd1,
    ST_TOO_HOT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_MUL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic search_done;
  } stat_t;

  typedef logic [12:0] mv_arr_t [ROM_POINTS];
  typedef logic [17:0] milli_arr_t [ROM_POINTS];
  typedef logic [VOL_W-1:0] vol_arr_t [ROM_POINTS];
  typedef logic signed [SLOPE_W-1:0] slope_arr_t [ROM_POINTS];

  localparam mv_arr_t VOL_MV = '{
    13'd4907,13'd4901,13'd4894,13'd4888,13'd4881,13'd4873,13'd4866,13'd4858,13'd4849,13'd4840,
    13'd4831,13'd4821,13'd4811,13'd4800,13'd4789,13'd4777,13'd4765,13'd4752,13'd4738,13'd4724,
    13'd4710,13'd4695,13'd4679,13'd4663,13'd4646,13'd4628,13'd4610,13'd4591,13'd4571,13'd4551,
    13'd4530,13'd4508,13'd4486,13'd4463,13'd4439,13'd4414,13'd4389,13'd4363,13'd4336,13'd4308,
    13'd4280,13'd4251,13'd4221,13'd4191,13'd4160,13'd4127,13'd4095,13'd4062,13'd4027,13'd3992,
    13'd3957,13'd3921,13'd3884,13'd3847,13'd3809,13'd3770,13'd3731,13'd3692,13'd3652,13'd3611,
    13'd3570,13'd3528,13'd3487,13'd3444,13'd3401,13'd3358,13'd3315,13'd3272,13'd3228,13'd3184,
    13'd3140,13'd3095,13'd3051,13'd3007,13'd2962,13'd2918,13'd2873,13'd2829,13'd2784,13'd2740,
    13'd2696,13'd2652,13'd2608,13'd2565,13'd2521,13'd2478,13'd2435,13'd2393,13'd2351,13'd2309,
    13'd2267,13'd2226,13'd2186,13'd2145,13'd2106,13'd2066,13'd2027,13'd1989,13'd1951,13'd1913,
    13'd1876,13'd1840,13'd1804,13'd1768,13'd1733,13'd1699,13'd1665,13'd1632,13'd1599,13'd1567,
    13'd1535,13'd1504,13'd1474,13'd1443,13'd1414,13'd1385,13'd1356,13'd1328,13'd1301,13'd1274,
    13'd1248,13'd1222,13'd1196,13'd1171,13'd1147,13'd1123,13'd1100,13'd1077,13'd1054,13'd1032,
    13'd1011,13'd990,13'd969,13'd949,13'd929,13'd910,13'd891,13'd873,13'd855,13'd837,
    13'd819,13'd803,13'd786,13'd770,13'd754,13'd738,13'd723,13'd708,13'd694,13'd680
  };

  localparam milli_arr_t SLOPE_MILLI = '{
    18'd166169,18'd158099,18'd150405,18'd142928,18'd135504,18'd129240,18'd122872,18'd117550,
    18'd111949,18'd107267,18'd100711,18'd97584,18'd92533,18'd89601,18'd84453,18'd81620,
    18'd78083,18'd74769,18'd71812,18'd68864,18'd66211,18'd63663,18'd61182,18'd58911,
    18'd56837,18'd54750,18'd52802,18'd50975,18'd49251,18'd47609,18'd46028,18'd44710,
    18'd43207,18'd41928,18'd40644,18'd39327,18'd38455,18'd37037,18'd36293,18'd35497,
    18'd34329,18'd33583,18'd32715,18'd31992,18'd31108,18'd30669,18'd30067,18'd29254,
    18'd28542,18'd28301,18'd27841,18'd27109,18'd26859,18'd26324,18'd25878,18'd25526,
    18'd25275,18'd25134,18'd24607,18'd24142,18'd24273,18'd23986,18'd23207,18'd23614,
    18'd23258,18'd23151,18'd22925,18'd22902,18'd22748,18'd22659,18'd22562,18'd22531,
    18'd22487,18'd22510,18'd22513,18'd22487,18'd22419,18'd22616,18'd22566,18'd22681,
    18'd22745,18'd22742,18'd23054,18'd23037,18'd23208,18'd23292,18'd23589,18'd23627,
    18'd24060,18'd24029,18'd24415,18'd24477,18'd24788,18'd25169,18'd25389,18'd25661,
    18'd25991,18'd26385,18'd26561,18'd27079,18'd27362,18'd28032,18'd28091,18'd28541,
    18'd29058,18'd29650,18'd29889,18'd30620,18'd30965,18'd31356,18'd32332,18'd32865,
    18'd32870,18'd34118,18'd34199,18'd34976,18'd35843,18'd36812,18'd37066,18'd38202,
    18'd38551,18'd38933,18'd40341,18'd40846,18'd42521,18'd42005,18'd43878,18'd44651,
    18'd45490,18'd46399,18'd47387,18'd48459,18'd49626,18'd50895,18'd52280,18'd51791,
    18'd54768,18'd55159,18'd56500,18'd57702,18'd58996,18'd60389,18'd61891,18'd62901,
    18'd64612,18'd66123,18'd67390,18'd69114,18'd70573,18'd72132
  };

  // millivolts to volts q16, round half up
  function automatic vol_arr_t build_vol();
    vol_arr_t r;
    longint   t;
    for (int k = 0; k < ROM_POINTS; k++) begin
      t    = (longint'(VOL_MV[k]) * 65536 + 500) / 1000;
      r[k] = VOL_W'(t);
    end
    return r;
  endfunction

  // millidegrees per volt to negative q10.8 (18-bit signed)
  function automatic slope_arr_t build_slope();
    slope_arr_t r;
    longint     t;
    for (int k = 0; k < ROM_POINTS; k++) begin
      t    = -((longint'(SLOPE_MILLI[k]) * 256 + 500) / 1000);
      r[k] = SLOPE_W'(t);
    end
    return r;
  endfunction

  localparam vol_arr_t   VOL_Q16   = build_vol();
  localparam slope_arr_t SLOPE_Q8  = build_slope();

endpackage

// File: hw/rtl/ttl_ctrl.sv
// ttl_ctrl: sequencing state machine for the thermistor linearizer
// depends on ttl_pkg; drives ttl_dp through cmd_t and watches stat_t
`timescale 1ns / 1ps
module ttl_ctrl
  import ttl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  result_valid_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_CHECK;
      S_CHECK:  state_d = stat_i.out_of_range ? S_FINISH : S_SEARCH;
      S_SEARCH: if (stat_i.search_done) state_d = S_MUL;
      S_MUL:    state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    valid_d = 1'b0;
    case (state_q)
      S_IDLE:   cmd_o.load = start_i;
      S_CHECK:  cmd_o.check = 1'b1;
      S_SEARCH: cmd_o.step = !stat_i.search_done;
      S_MUL:    cmd_o.mul = 1'b1;
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        valid_d      = 1'b1;
      end
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

endmodule

// File: hw/rtl/ttl_dp.sv
// ttl_dp: voltage scaling, binary segment search, interpolation and result registers
// depends on ttl_pkg (tables, types); commanded by ttl_ctrl
`timescale 1ns / 1ps
module ttl_dp
  import ttl_pkg::*;
#(
  parameter int EFF_POINTS     = TABLE_POINTS_DEF,
  parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [CODE_W-1:0]        adc_code_i,
  output stat_t                    stat_o,
  output logic signed [TEMP_W-1:0] temperature_q8_o,
  output logic [STATUS_W-1:0]      status_o
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(EFF_POINTS - 1);
  localparam int P_W = SLOPE_W + V_W + 1;
  // code * 5 * 2^16 / full scale as a reciprocal multiply, exact for 13-bit numerators
  localparam int RECIP_SH = 29;
  localparam logic [37:0] RECIP = 38'(((longint'(1) <<< (RECIP_SH + 16)) +
                                       longint'(ADC_FULL_SCALE) - 1) /
                                      longint'(ADC_FULL_SCALE));

  logic [V_W-1:0]            v_q;
  logic [12:0]               code5;
  logic [50:0]               v_prod;
  logic [IDX_W-1:0]          lo_q, hi_q;
  logic [IDX_W-1:0]          mid;
  logic [IDX_W:0]            sum;
  logic [IDX_W-1:0]          seg;
  logic                      ge_top, lt_bot;
  status_e                   st_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [V_W:0]       diff;
  logic signed [P_W-1:0]     p_rnd;
  logic signed [P_W-1:0]     p_sh;
  logic signed [IDX_W+1:0]   deg;
  logic signed [TEMP_W-1:0]  temp;
  logic signed [TEMP_W-1:0]  temp_q;
  logic [STATUS_W-1:0]       status_q;

  assign code5  = 13'(adc_code_i) * 13'd5;
  assign v_prod = 51'(code5) * 51'(RECIP);

  assign ge_top = v_q >= V_W'(VOL_Q16[0]);
  assign lt_bot = v_q <  V_W'(VOL_Q16[LAST]);
  assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum[IDX_W:1];
  assign seg    = lo_q - IDX_W'(1);

  assign stat_o.out_of_range = ge_top || lt_bot;
  assign stat_o.search_done  = (lo_q == hi_q);

  // diff is never positive inside a segment
  assign diff  = $signed({1'b0, v_q}) - $signed((V_W + 1)'(VOL_Q16[seg]));
  assign p_rnd = p_q + P_W'(32768);
  assign p_sh  = p_rnd >>> 16;
  assign deg   = $signed({2'b00, seg}) - (IDX_W + 2)'(TEMP_OFFSET);
  assign temp  = p_sh[TEMP_W-1:0] + {deg[7:0], 8'h00};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= v_prod[RECIP_SH +: V_W];
    end
    if (cmd_i.check) begin
      lo_q <= IDX_W'(1);
      hi_q <= LAST;
      if (ge_top)      st_q <= ST_TOO_COLD;
      else if (lt_bot) st_q <= ST_TOO_HOT;
      else             st_q <= ST_VALID;
    end
    // first table point (lowest index) at or below v closes the segment
    if (cmd_i.step) begin
      if (V_W'(VOL_Q16[mid]) <= v_q) hi_q <= mid;
      else                           lo_q <= mid + IDX_W'(1);
    end
    if (cmd_i.mul) begin
      p_q <= P_W'(SLOPE_Q8[seg] * diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= '0;
      status_q <= '0;
    end else if (cmd_i.finish) begin
      temp_q   <= (st_q == ST_VALID) ? temp : '0;
      status_q <= st_q;
    end
  end

  assign temperature_q8_o = temp_q;
  assign status_o         = status_q;

endmodule

// File: hw/rtl/thermistor_table_linearizer.sv
// thermistor_table_linearizer: top level, joins controller and datapath
// depends on ttl_pkg, ttl_ctrl and ttl_dp
`timescale 1ns / 1ps
// one 10-bit converter code per request, one temperature out per request.
// start_i is taken when busy_o is low; the result shows on temperature_q8_o
// and status_o for exactly one cycle with result_valid_o high, and the
// receiver cannot stall it, so it must be captured in that cycle. result
// ports hold their value until the next result. an out-of-range voltage goes
// from the accepting cycle through check and finish to the strobe; any other
// voltage runs the binary search, which probes one table entry per cycle, then
// a multiply, before finish and the strobe. busy_o drops in the cycle the
// result strobe is up, so a new request may be issued then. status: 0 valid,
// 1 too cold (voltage at or above the table top), 2 too hot (below the table
// bottom); temperature is zero for both out-of-range codes.
module thermistor_table_linearizer
  import ttl_pkg::*;
#(
  parameter int TABLE_POINTS   = TABLE_POINTS_DEF,
  parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [CODE_W-1:0]        adc_code_i,
  output logic                     result_valid_o,
  output logic signed [TEMP_W-1:0] temperature_q8_o,
  output logic [STATUS_W-1:0]      status_o
);

  // search is bounded to the points the rom holds
  localparam int EFF_POINTS = (TABLE_POINTS < ROM_POINTS) ? TABLE_POINTS : ROM_POINTS;

  cmd_t  cmd;
  stat_t stat;

  ttl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  ttl_dp #(
    .EFF_POINTS     (EFF_POINTS),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .adc_code_i       (adc_code_i),
    .stat_o           (stat),
    .temperature_q8_o (temperature_q8_o),
    .status_o         (status_o)
  );

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for thermistor_table_linearizer
// drives converter codes, predicts temperature and status per request; needs ttl_pkg
`timescale 1ns / 1ps
module tb_top;
  import ttl_pkg::*;

  localparam int N_RANDOM = 930;

  typedef struct {
    logic [TEMP_W-1:0]   temp;
    logic [STATUS_W-1:0] st;
  } reading_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [CODE_W-1:0]        adc_code_i = '0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic signed [TEMP_W-1:0] temperature_q8_o;
  logic [STATUS_W-1:0]      status_o;

  logic [CODE_W-1:0] code_queue[$];
  reading_t          expected_readings[$];
  int                mismatches = 0;
  bit                stimulus_done = 1'b0;
  int                gap_left = 0;

  // table rebuilt locally from millivolt and millidegree figures
  longint vol_tab[ROM_POINTS];
  longint slope_tab[ROM_POINTS];

  always #5 clk_i = ~clk_i;

  thermistor_table_linearizer dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .adc_code_i,
    .result_valid_o, .temperature_q8_o, .status_o
  );

  function automatic reading_t linearize(logic [CODE_W-1:0] code);
    reading_t r;
    longint   v;
    longint   p;
    longint   q;
    r.temp = '0;
    r.st   = ST_VALID;
    v = (longint'(code) * 5 * 65536) / ADC_FULL_SCALE_DEF;
    if (v >= vol_tab[0]) r.st = ST_TOO_COLD;
    else if (v < vol_tab[ROM_POINTS-1]) r.st = ST_TOO_HOT;
    else begin
      for (int i = 0; i < ROM_POINTS - 1; i++) begin
        if (vol_tab[i] >= v && v >= vol_tab[i+1]) begin
          p = slope_tab[i] * (v - vol_tab[i]) + 32768;
          // floor division by 2^16, sign safe
          q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
          r.temp = TEMP_W'(q + (i - TEMP_OFFSET) * 256);
          break;
        end
      end
    end
    return r;
  endfunction

  // driver: one request at a time, random gap between requests
  // start is only raised while busy is low, so it is taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i) begin
        start_i <= 1'b0;
        gap_left <= $urandom_range(0, 10);
      end else begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (code_queue.size() > 0 && !busy_o) begin
          adc_code_i <= code_queue[0];
          expected_readings.push_back(linearize(code_queue[0]));
          void'(code_queue.pop_front());
          start_i <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result temp=%0d status=%0d",
                                       temperature_q8_o, status_o);
      end else begin
        e = expected_readings.pop_front();
        if (temperature_q8_o !== e.temp || status_o !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                     $signed(e.temp), e.st, temperature_q8_o, status_o);
        end
      end
    end
  end

  // stimulus plus end of run
  initial begin
    int seg;
    for (int k = 0; k < ROM_POINTS; k++) begin
      vol_tab[k]   = (longint'(VOL_MV[k]) * 65536 + 500) / 1000;
      slope_tab[k] = -((longint'(SLOPE_MILLI[k]) * 256 + 500) / 1000);
    end
    // directed: field extremes, both range edges, codes near table points
    code_queue = '{10'd0, 10'd1023, 10'd1022, 10'd1005, 10'd1004, 10'd139, 10'd140,
                   10'd138, 10'd512, 10'd511, 10'd341, 10'd682, 10'd256, 10'd768,
                   10'd1000, 10'd142, 10'd145, 10'd993, 10'd700, 10'd300};
    // random: mostly in-table codes, with some out-of-range ones
    for (int n = 0; n < N_RANDOM; n++) begin
      seg = $urandom_range(0, 9);
      if (seg == 0) code_queue.push_back(CODE_W'($urandom_range(0, 1023)));
      else code_queue.push_back(CODE_W'($urandom_range(135, 1010)));
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (code_queue.size() == 0 && !start_i);
    wait (expected_readings.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("thermistor_table_linearizer test passed");
    else
      $display("thermistor_table_linearizer test failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("thermistor_table_linearizer test failed");
    $finish;
  end

endmodule
